/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the box window sum block.
// Needs a clock named clock and a synchronous active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

/* rtl/cbws_pkg.sv */
// Shared constants and types of the clipped box window sum block.
// No dependencies; used by clipped_box_window_sum_top.
`timescale 1ns / 1ps

package cbws_pkg;

   // Fixed field widths of the channels
   localparam int OUT_SUM_BITS   = 24;
   localparam int OUT_POS_BITS   = 11;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;
   localparam int RADIUS_BITS    = 3;
   localparam int DIM_BITS       = 12;

   // Largest window sum that fits the result field
   localparam logic [OUT_SUM_BITS-1:0] SUM_LIMIT = {OUT_SUM_BITS{1'b1}};

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT = 2'd2;

   // Request codes
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // Reset values of the configuration registers
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 3'd1;
   localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = 12'd640;
   localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = 12'd480;

   // One result item
   typedef struct packed {
      logic [OUT_SUM_BITS-1:0] window_sum;
      logic [OUT_POS_BITS-1:0] pixel_row;
      logic [OUT_POS_BITS-1:0] pixel_col;
      logic                    frame_end;
   } rsp_item_type;

endpackage

/* rtl/cbws_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// A read and a write to the same address in one cycle return the old contents.
// No dependencies.
`timescale 1ns / 1ps

module cbws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/clipped_box_window_sum_top.sv */
// Top level of the clipped box window sum: streaming (2r+1) square box sum over a raster image.
// Depends on cbws_pkg, cbws_ram and assert_macros.svh.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_type, req_pixel_value
//   rsp      out        rsp_valid/stall    rsp_window_sum, rsp_pixel_row/col, rsp_frame_end
//   csr      in         csr_valid/ready    csr_index, csr_data
//
// One item per clock while req_stall is low; a result passes the pixel RAM read, the column
// sum update, the prefix stage and the final subtract on its way to the result register.
// Results lag the input by r rows plus r pixels; flush requests push out the last ones.
// Reset clears control state only; column sums of the first row ignore stored data,
// so no clearing pass runs. req_stall rises only while two results wait in the buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clipped_box_window_sum_top #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int MAX_RADIUS = 7,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic [PIXEL_BITS-1:0]                  req_pixel_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [cbws_pkg::OUT_SUM_BITS-1:0]      rsp_window_sum,
   output logic [cbws_pkg::OUT_POS_BITS-1:0]      rsp_pixel_row,
   output logic [cbws_pkg::OUT_POS_BITS-1:0]      rsp_pixel_col,
   output logic                                   rsp_frame_end,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cbws_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [cbws_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int WID_BITS     = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS     = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
   localparam int RAD_BITS     = $clog2(MAX_RADIUS + 1);
   localparam int TAPS         = 2 * MAX_RADIUS + 1;
   localparam int TAP_BITS     = $clog2(TAPS);
   localparam int RING_BITS    = $clog2(TAPS);
   localparam int HIST_DEPTH   = TAPS * MAX_WIDTH;
   localparam int HIST_BITS    = $clog2(HIST_DEPTH);
   localparam int COLSUM_BITS  = PIXEL_BITS + $clog2(TAPS);
   localparam int SUM_BITS     = PIXEL_BITS + $clog2(TAPS * TAPS);
   localparam int POS_BITS     = cbws_pkg::OUT_POS_BITS;
   localparam int OUT_SLOTS    = 2;

   // Emission tag carried along with each stream item
   typedef struct packed {
      logic                emit;
      logic                use_total;
      logic                sub_en;
      logic                last;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
   } tag_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]  pix;
      logic [COL_BITS-1:0]    col;
      logic                   first_row;
      logic                   sub_en_v;
      logic                   bypass;
      logic [COLSUM_BITS-1:0] bypass_data;
      logic                   first_col;
      logic                   row_end;
      logic [TAP_BITS-1:0]    tap_sel;
      tag_type                tag;
   } s1_type;

   typedef struct packed {
      logic [COLSUM_BITS-1:0] colsum;
      logic                   first_col;
      logic                   row_end;
      logic [TAP_BITS-1:0]    tap_sel;
      tag_type                tag;
   } s2_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] top;
      logic [SUM_BITS-1:0] sub;
      tag_type             tag;
   } s3_type;

   // Configuration and latched frame geometry
   logic [cbws_pkg::RADIUS_BITS-1:0] cfg_radius_ff;
   logic [cbws_pkg::DIM_BITS-1:0]    cfg_width_ff;
   logic [cbws_pkg::DIM_BITS-1:0]    cfg_height_ff;
   logic [WID_BITS-1:0]              eff_w_ff;
   logic [ROW_BITS-1:0]              eff_h_ff;
   logic [RAD_BITS-1:0]              eff_r_ff;

   // Position counters
   logic [ROW_BITS-1:0]  in_row_ff;
   logic [COL_BITS-1:0]  in_col_ff;
   logic                 in_done_ff;
   logic [ROW_BITS-1:0]  em_row_ff;
   logic [COL_BITS-1:0]  em_col_ff;
   logic [RING_BITS-1:0] ring_row_ff;
   logic [HIST_BITS-1:0] ring_base_ff;

   // Pipeline
   logic   s1_valid_ff, s2_valid_ff, s3_valid_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic [SUM_BITS-1:0] taps_ff [TAPS];
   logic [SUM_BITS-1:0] row_total_ff;

   // Result buffer
   logic [1:0]             out_count_ff, out_count_in;
   cbws_pkg::rsp_item_type slot0_ff, slot1_ff, result;

   // Stage 0 signals
   logic [WID_BITS-1:0]   cand_w, geo_w, w_half;
   logic [ROW_BITS-1:0]   cand_h, geo_h, h_half;
   logic [RAD_BITS-1:0]   cand_r, geo_r, r_a, r_b;
   logic                  frame_idle, is_pixel, take, step, advance;
   logic [PIXEL_BITS-1:0] pix;
   logic                  in_last_col, em_last_col, em_last, emit;
   logic [HIST_BITS-1:0]  hist_addr;
   logic [RING_BITS-1:0]  ring_top;

   // Later stage signals
   logic [PIXEL_BITS-1:0]  hist_rd, hist_old;
   logic [COLSUM_BITS-1:0] colsum_rd, col_old, colsum_new;
   logic [SUM_BITS-1:0]    prefix_new, diff;
   logic                   push, pop;

   assign csr_ready = 1'b1;
   assign advance   = (out_count_ff != 2'(OUT_SLOTS));
   assign req_stall = !advance;
   assign take      = req_valid && !req_stall;
   assign is_pixel  = (req_type == cbws_pkg::REQ_PIXEL);
   assign step      = take && (is_pixel ? !in_done_ff : in_done_ff);
   assign pix       = is_pixel ? req_pixel_value : '0;

   // Geometry clamped from the registers, taken at the first pixel of a frame
   always_comb begin
      if (cfg_width_ff == '0) begin
         cand_w = WID_BITS'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         cand_w = WID_BITS'(MAX_WIDTH);
      end else begin
         cand_w = WID_BITS'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         cand_h = ROW_BITS'(1);
      end else if (32'(cfg_height_ff) > MAX_HEIGHT) begin
         cand_h = ROW_BITS'(MAX_HEIGHT);
      end else begin
         cand_h = ROW_BITS'(cfg_height_ff);
      end
      w_half = (cand_w - WID_BITS'(1)) >> 1;
      h_half = (cand_h - ROW_BITS'(1)) >> 1;
      r_a = (32'(cfg_radius_ff) > MAX_RADIUS) ? RAD_BITS'(MAX_RADIUS)
                                              : RAD_BITS'(cfg_radius_ff);
      r_b = (32'(r_a) > 32'(w_half)) ? RAD_BITS'(w_half) : r_a;
      cand_r = (32'(r_b) > 32'(h_half)) ? RAD_BITS'(h_half) : r_b;
   end

   assign frame_idle = (in_row_ff == '0) && (in_col_ff == '0) && !in_done_ff;
   assign geo_w = frame_idle ? cand_w : eff_w_ff;
   assign geo_h = frame_idle ? cand_h : eff_h_ff;
   assign geo_r = frame_idle ? cand_r : eff_r_ff;

   // Stage 0: positions, emission decision, RAM addresses
   always_comb begin
      in_last_col = (WID_BITS'(in_col_ff) + WID_BITS'(1)) == geo_w;
      em_last_col = (WID_BITS'(em_col_ff) + WID_BITS'(1)) == geo_w;
      em_last     = em_last_col && ((em_row_ff + ROW_BITS'(1)) == geo_h);
      emit = !is_pixel || (in_row_ff > ROW_BITS'(geo_r)) ||
             ((in_row_ff == ROW_BITS'(geo_r)) && (WID_BITS'(in_col_ff) >= WID_BITS'(geo_r)));
      hist_addr = ring_base_ff + HIST_BITS'(in_col_ff);
      ring_top  = RING_BITS'({geo_r, 1'b0});

      s1_in.pix         = pix;
      s1_in.col         = in_col_ff;
      s1_in.first_row   = (in_row_ff == '0);
      s1_in.sub_en_v    = in_row_ff >= ROW_BITS'({geo_r, 1'b1});
      s1_in.bypass      = s1_valid_ff && (s1_ff.col == in_col_ff);
      s1_in.bypass_data = colsum_new;
      s1_in.first_col   = (in_col_ff == '0);
      s1_in.row_end     = in_last_col;
      s1_in.tap_sel     = TAP_BITS'({geo_r, 1'b0});
      s1_in.tag.emit    = emit;
      s1_in.tag.last    = em_last;
      s1_in.tag.use_total = ((WID_BITS + 1)'(em_col_ff) + (WID_BITS + 1)'(geo_r))
                            >= (WID_BITS + 1)'(geo_w);
      s1_in.tag.sub_en  = WID_BITS'(em_col_ff) > WID_BITS'(geo_r);
      s1_in.tag.row     = POS_BITS'(em_row_ff);
      s1_in.tag.col     = POS_BITS'(em_col_ff);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_radius_ff <= cbws_pkg::RADIUS_RESET;
         cfg_width_ff  <= cbws_pkg::WIDTH_RESET;
         cfg_height_ff <= cbws_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cbws_pkg::CSR_RADIUS: cfg_radius_ff <= cbws_pkg::RADIUS_BITS'(csr_data);
            cbws_pkg::CSR_WIDTH:  cfg_width_ff  <= csr_data;
            cbws_pkg::CSR_HEIGHT: cfg_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Frame counters, ring pointer and geometry latch
   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_done_ff   <= 1'b0;
         em_row_ff    <= '0;
         em_col_ff    <= '0;
         ring_row_ff  <= '0;
         ring_base_ff <= '0;
         eff_w_ff     <= WID_BITS'(1);
         eff_h_ff     <= ROW_BITS'(1);
         eff_r_ff     <= '0;
      end else if (step) begin
         if (is_pixel && frame_idle) begin
            eff_w_ff <= cand_w;
            eff_h_ff <= cand_h;
            eff_r_ff <= cand_r;
         end
         if (emit && em_last) begin
            // last result of the frame: start over
            in_row_ff    <= '0;
            in_col_ff    <= '0;
            in_done_ff   <= 1'b0;
            em_row_ff    <= '0;
            em_col_ff    <= '0;
            ring_row_ff  <= '0;
            ring_base_ff <= '0;
         end else begin
            if (in_last_col) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + ROW_BITS'(1);
               if (is_pixel && ((in_row_ff + ROW_BITS'(1)) == geo_h)) begin
                  in_done_ff <= 1'b1;
               end
               if (ring_row_ff == ring_top) begin
                  ring_row_ff  <= '0;
                  ring_base_ff <= '0;
               end else begin
                  ring_row_ff  <= ring_row_ff + RING_BITS'(1);
                  ring_base_ff <= ring_base_ff + HIST_BITS'(MAX_WIDTH);
               end
            end else begin
               in_col_ff <= in_col_ff + COL_BITS'(1);
            end
            if (emit) begin
               if (em_last_col) begin
                  em_col_ff <= '0;
                  em_row_ff <= em_row_ff + ROW_BITS'(1);
               end else begin
                  em_col_ff <= em_col_ff + COL_BITS'(1);
               end
            end
         end
      end
   end

   // Pixel history ring: old pixel of this column 2r+1 rows back, replaced by the new one
   cbws_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (hist_addr),
      .wr_data (pix),
      .rd_en   (step),
      .rd_addr (hist_addr),
      .rd_data (hist_rd)
   );

   // Vertical sums per column
   cbws_ram #(
      .WIDTH (COLSUM_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_colsum_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff && advance),
      .wr_addr (s1_ff.col),
      .wr_data (colsum_new),
      .rd_en   (step),
      .rd_addr (in_col_ff),
      .rd_data (colsum_rd)
   );

   // Stage 1: column sum update, forwarding a write still in flight
   always_comb begin
      col_old = s1_ff.first_row ? '0 : (s1_ff.bypass ? s1_ff.bypass_data : colsum_rd);
      hist_old = s1_ff.sub_en_v ? hist_rd : '0;
      colsum_new = col_old + COLSUM_BITS'(s1_ff.pix) - COLSUM_BITS'(hist_old);
      s2_in.colsum    = colsum_new;
      s2_in.first_col = s1_ff.first_col;
      s2_in.row_end   = s1_ff.row_end;
      s2_in.tap_sel   = s1_ff.tap_sel;
      s2_in.tag       = s1_ff.tag;
   end

   // Stage 2: row prefix sum and the two prefix values that bound the window
   always_comb begin
      prefix_new = (s2_ff.first_col ? '0 : taps_ff[0]) + SUM_BITS'(s2_ff.colsum);
      s3_in.top  = s2_ff.tag.use_total ? row_total_ff : prefix_new;
      s3_in.sub  = s2_ff.tag.sub_en ? taps_ff[s2_ff.tap_sel] : '0;
      s3_in.tag  = s2_ff.tag;
   end

   // Stage 3: window sum with saturation
   always_comb begin
      diff = s3_ff.top - s3_ff.sub;
      if (diff > SUM_BITS'(cbws_pkg::SUM_LIMIT)) begin
         result.window_sum = cbws_pkg::SUM_LIMIT;
      end else begin
         result.window_sum = cbws_pkg::OUT_SUM_BITS'(diff);
      end
      result.pixel_row = s3_ff.tag.row;
      result.pixel_col = s3_ff.tag.col;
      result.frame_end = s3_ff.tag.last;
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= step;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Pipeline payload and prefix delay line
   always_ff @(posedge clock) begin
      if (advance) begin
         if (step) begin
            s1_ff <= s1_in;
         end
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         if (s2_valid_ff) begin
            taps_ff[0] <= prefix_new;
            for (int k = 1; k < TAPS; k++) begin
               taps_ff[k] <= taps_ff[k-1];
            end
            if (s2_ff.row_end) begin
               row_total_ff <= prefix_new;
            end
         end
      end
   end

   // Two-entry result buffer
   assign pop  = rsp_valid && !rsp_stall;
   assign push = s3_valid_ff && s3_ff.tag.emit && advance;
   assign out_count_in = out_count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff <= '0;
      end else begin
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      priority if (pop && (out_count_ff == 2'(OUT_SLOTS))) begin
         slot0_ff <= slot1_ff;
      end else if (push && (pop || (out_count_ff == '0))) begin
         slot0_ff <= result;
      end
      if (push && !pop && (out_count_ff == 2'd1)) begin
         slot1_ff <= result;
      end
   end

   assign rsp_valid      = (out_count_ff != '0);
   assign rsp_window_sum = slot0_ff.window_sum;
   assign rsp_pixel_row  = slot0_ff.pixel_row;
   assign rsp_pixel_col  = slot0_ff.pixel_col;
   assign rsp_frame_end  = slot0_ff.frame_end;

   // Checks
   `ASSERT_NEVER(a_buffer_overflow, push && !pop && (out_count_ff == 2'(OUT_SLOTS)),
                 "result pushed into a full buffer")
   `ASSERT_NEVER(a_in_col_range, WID_BITS'(in_col_ff) >= eff_w_ff,
                 "input column beyond frame width")
   `ASSERT_NEVER(a_em_col_range, WID_BITS'(em_col_ff) >= eff_w_ff,
                 "output column beyond frame width")
   `ASSERT_CLK(a_done_row, in_done_ff |-> (in_row_ff >= eff_h_ff),
               "frame marked complete before its last row")
   `ASSERT_CLK(a_full_stalls, (out_count_ff == 2'd1) && push && !pop |=> req_stall,
               "input not stalled with a full result buffer")

endmodule
